// ----- rtl/ipalu_pkg.sv -----
// ipalu_pkg: shared types and constants of the packet alu slave
// request codes, command kinds passed from front to back, reset values
// no dependencies
`default_nettype none

package ipalu_pkg;

	localparam int unsigned PKT_LEN = 12;
	localparam int unsigned Q_DEPTH = 2;

	localparam logic [2:0] REQ_RX     = 3'd0;
	localparam logic [2:0] REQ_TX     = 3'd1;
	localparam logic [2:0] REQ_RXADDR = 3'd2;
	localparam logic [2:0] REQ_TXADDR = 3'd3;
	localparam logic [2:0] REQ_STOP   = 3'd4;

	localparam logic [31:0] LAST_RESET   = 32'hAABBCCDD;
	localparam logic [31:0] RESULT_RESET = 32'h78563412;

	typedef logic [3:0] kind_t;

	localparam kind_t K_NONE  = 4'd0;
	localparam kind_t K_TX    = 4'd1;
	localparam kind_t K_TXCLR = 4'd2;
	localparam kind_t K_STOP  = 4'd3;
	localparam kind_t K_ADD   = 4'd4;
	localparam kind_t K_MUL   = 4'd5;
	localparam kind_t K_DIV   = 4'd6;
	localparam kind_t K_SUB   = 4'd7;
	localparam kind_t K_KEEP  = 4'd8;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] opa;
		logic [31:0] opb;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ipalu_in_if.sv -----
// ipalu_in_if: valid/ready channel that carries slave events into the block
// no dependencies
`default_nettype none

interface ipalu_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/ipalu_out_if.sv -----
// ipalu_out_if: valid/ready channel that carries one response item per event
// no dependencies
`default_nettype none

interface ipalu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       packet_done;
	logic       ack_enable;

	modport source (output valid, output tx_byte, output packet_done, output ack_enable,
		input ready);
	modport sink (input valid, input tx_byte, input packet_done, input ack_enable,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/ipalu_front.sv -----
// ipalu_front: accepts slave events, collects packet bytes, classifies each item
// into a command for the back end; depends on ipalu_pkg and ipalu_in_if
`default_nettype none

module ipalu_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ipalu_in_if.sink         req,
	input  wire logic        q_full,
	output logic             push,
	output ipalu_pkg::cmd_t  push_cmd
);
	import ipalu_pkg::*;

	logic [7:0]  rx_bytes [PKT_LEN];
	logic [3:0]  rx_count_q;
	logic        last_byte;
	logic [31:0] op_word;

	assign req.ready = !q_full;
	assign push      = req.valid && req.ready;
	assign last_byte = (rx_count_q == 4'(PKT_LEN - 1));
	assign op_word   = {req.rx_byte, rx_bytes[10], rx_bytes[9], rx_bytes[8]};

	always_comb begin
		push_cmd.kind = K_NONE;
		push_cmd.opa  = {rx_bytes[3], rx_bytes[2], rx_bytes[1], rx_bytes[0]};
		push_cmd.opb  = {rx_bytes[7], rx_bytes[6], rx_bytes[5], rx_bytes[4]};
		case (req.req_type)
			REQ_RX: begin
				if (last_byte) begin
					if (op_word[31:2] != 30'd0) begin
						push_cmd.kind = K_KEEP;
					end else begin
						case (op_word[1:0])
							2'd0:    push_cmd.kind = K_ADD;
							2'd1:    push_cmd.kind = K_MUL;
							2'd2:    push_cmd.kind = K_DIV;
							default: push_cmd.kind = K_SUB;
						endcase
					end
				end
			end
			REQ_TX:     push_cmd.kind = K_TX;
			REQ_TXADDR: push_cmd.kind = K_TXCLR;
			REQ_STOP:   push_cmd.kind = K_STOP;
			default:    push_cmd.kind = K_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push && req.req_type == REQ_RX && !last_byte) begin
			rx_bytes[rx_count_q] <= req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= 4'd0;
		end else if (push) begin
			if (req.req_type == REQ_RX) begin
				rx_count_q <= last_byte ? 4'd0 : rx_count_q + 4'd1;
			end else if (req.req_type == REQ_RXADDR) begin
				rx_count_q <= 4'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ipalu_queue.sv -----
// ipalu_queue: short command fifo between front and back end
// depends on ipalu_pkg
`default_nettype none

module ipalu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ipalu_pkg::cmd_t push_cmd,
	output logic                 full,
	output logic                 q_valid,
	output ipalu_pkg::cmd_t      head,
	input  wire logic            pop
);
	import ipalu_pkg::*;

	localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	cmd_t            mem [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ipalu_back.sv -----
// ipalu_back: executes commands: transmit byte index, result update with
// multiply and radix-2 divider, response register; depends on ipalu_pkg, ipalu_out_if
`default_nettype none

module ipalu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire ipalu_pkg::cmd_t head,
	output logic                 pop,
	ipalu_out_if.source          rsp
);
	import ipalu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  tx_count_q;
	logic [31:0] result_q;
	logic [31:0] last_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic        out_valid_q;
	logic [7:0]  tx_byte_q;
	logic        done_q;
	logic        ack_q;

	logic        free;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic [31:0] product;
	logic [7:0]  sel_byte;

	assign free    = !out_valid_q || rsp.ready;
	assign pop     = (state_q == ST_IDLE) && q_valid && free;
	assign rem_sh  = {rem_q, a_q[31]};
	assign diff    = rem_sh - {1'b0, b_q};
	assign product = a_q * b_q;

	always_comb begin
		case (tx_count_q)
			2'd0:    sel_byte = result_q[7:0];
			2'd1:    sel_byte = result_q[15:8];
			2'd2:    sel_byte = result_q[23:16];
			default: sel_byte = result_q[31:24];
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.tx_byte     = tx_byte_q;
	assign rsp.packet_done = done_q;
	assign rsp.ack_enable  = ack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tx_count_q  <= 2'd0;
			result_q    <= RESULT_RESET;
			last_q      <= LAST_RESET;
			out_valid_q <= 1'b0;
			tx_byte_q   <= 8'd0;
			done_q      <= 1'b0;
			ack_q       <= 1'b0;
			a_q         <= 32'd0;
			b_q         <= 32'd0;
			rem_q       <= 32'd0;
			cnt_q       <= 5'd0;
			neg_q       <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						tx_byte_q   <= 8'd0;
						done_q      <= 1'b0;
						ack_q       <= 1'b0;
						case (head.kind)
							K_TX: begin
								tx_byte_q  <= sel_byte;
								tx_count_q <= tx_count_q + 2'd1;
							end
							K_TXCLR: begin
								tx_count_q <= 2'd0;
							end
							K_STOP: begin
								tx_count_q <= 2'd0;
								ack_q      <= 1'b1;
							end
							K_ADD: begin
								result_q <= head.opa + head.opb;
								last_q   <= head.opa + head.opb;
								done_q   <= 1'b1;
							end
							K_SUB: begin
								result_q <= head.opa - head.opb;
								last_q   <= head.opa - head.opb;
								done_q   <= 1'b1;
							end
							K_KEEP: begin
								result_q <= last_q;
								done_q   <= 1'b1;
							end
							K_MUL: begin
								out_valid_q <= 1'b0;
								a_q         <= head.opa;
								b_q         <= head.opb;
								state_q     <= ST_MUL;
							end
							K_DIV: begin
								if (head.opb == 32'd0) begin
									result_q <= 32'd0;
									last_q   <= 32'd0;
									done_q   <= 1'b1;
								end else begin
									out_valid_q <= 1'b0;
									a_q     <= head.opa[31] ? 32'd0 - head.opa : head.opa;
									b_q     <= head.opb[31] ? 32'd0 - head.opb : head.opb;
									neg_q   <= head.opa[31] ^ head.opb[31];
									rem_q   <= 32'd0;
									cnt_q   <= 5'd31;
									state_q <= ST_DIV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					result_q    <= product;
					last_q      <= product;
					out_valid_q <= 1'b1;
					tx_byte_q   <= 8'd0;
					done_q      <= 1'b1;
					ack_q       <= 1'b0;
					state_q     <= ST_IDLE;
				end
				ST_DIV: begin
					// remainder stays below the divisor, so its top bit is always clear
					if (!diff[32]) begin
						rem_q <= diff[31:0];
						a_q   <= {a_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						a_q   <= {a_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					result_q    <= neg_q ? 32'd0 - a_q : a_q;
					last_q      <= neg_q ? 32'd0 - a_q : a_q;
					out_valid_q <= 1'b1;
					tx_byte_q   <= 8'd0;
					done_q      <= 1'b1;
					ack_q       <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/i2c_slave_packet_alu_core.sv -----
// Byte side of a bus slave that works as a remote alu. Every event item on req
// (byte received, transmit request, address match, stop) gives exactly one item
// on rsp. Twelve received bytes form operand one, operand two and the opcode as
// little-endian words; the twelfth byte triggers add, multiply, divide or subtract
// (other opcodes keep the last result) and raises packet_done. Transmit requests
// return the result least significant byte first. A two-entry command queue
// decouples intake from execution, so req keeps accepting while a response waits.
// A multiply, or a divide at one quotient bit per cycle in the restoring divider,
// runs first. A new item is accepted in any cycle the queue has room.
`default_nettype none

module i2c_slave_packet_alu_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ipalu_in_if.sink    req,
	ipalu_out_if.source rsp
);
	import ipalu_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic q_valid;
	cmd_t head;
	logic pop;

	ipalu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ipalu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop)
	);

	ipalu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/ipalu_chk.sv -----
// ipalu_chk: port-level checks of the packet alu slave, bound to the top level
// depends on i2c_slave_packet_alu_core port names only
`default_nettype none

module ipalu_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] tx_byte,
	input wire logic       packet_done,
	input wire logic       ack_enable
);
	logic [3:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(tx_byte) && $stable(packet_done)
			&& $stable(ack_enable))
		else $error("response changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({tx_byte != 8'd0, packet_done, ack_enable}) <= 1)
		else $error("response mixes byte, done and ack");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("response without an accepted item");

endmodule

bind i2c_slave_packet_alu_core ipalu_chk u_ipalu_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.tx_byte     (rsp.tx_byte),
	.packet_done (rsp.packet_done),
	.ack_enable  (rsp.ack_enable)
);

`default_nettype wire
